>>> rtl/pos_list_pkg.sv
// package for the positional list block: sizes, codes and transfer structs
// no dependencies; used by rtl/positional_list_insert_delete.sv
package pos_list_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_EMPTY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [31:0] value;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [7:0]         entry_count;
  } result_t;

endpackage

>>> rtl/positional_list_insert_delete.sv
// top level of the positional list: ordered register row with insert/delete shifting
// depends on rtl/pos_list_pkg.sv
//
//   channel  | ports              | transfer
//   ---------+--------------------+--------------------------------
//   command  | start, busy, cmd   | start high while busy low
//   result   | done, result       | done high for one cycle
//
// one command per cycle; busy stays low. the command is registered, then
// every cell picks keep / shift / load from a position compare in parallel,
// and the result is registered with done from the registered command.
// reset clears the count; stored values hold until written. results cannot
// be stalled.
module positional_list_insert_delete (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pos_list_pkg::cmd_t    cmd,
  output logic                  done,
  output pos_list_pkg::result_t result
);

  localparam int CAP   = pos_list_pkg::CAPACITY;
  localparam int IDX_W = pos_list_pkg::IDX_W;
  localparam int CNT_W = pos_list_pkg::CNT_W;
  localparam int CMP_W = pos_list_pkg::CMP_W;

  logic                     cmd_valid;
  pos_list_pkg::cmd_t       cmd_q;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [31:0]              stored [CAP];
  logic [31:0]              stored_next [CAP];
  pos_list_pkg::result_t    result_next;

  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         pos_m1;
  logic [IDX_W-1:0]         pos_idx;
  logic                     do_ins;
  logic                     do_del;
  pos_list_pkg::status_t    status;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start;
    end
    if (start) begin
      cmd_q <= cmd;
    end
  end

  assign pos_ext = CMP_W'(cmd_q.position);
  assign cnt_ext = CMP_W'(count);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign pos_idx = pos_m1[IDX_W-1:0];

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    status     = pos_list_pkg::ST_BAD_POS;
    count_next = count;
    unique case (cmd_q.operation)
      pos_list_pkg::OP_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          status = pos_list_pkg::ST_BAD_POS;
        end else if (cnt_ext == CMP_W'(CAP)) begin
          status = pos_list_pkg::ST_FULL;
        end else begin
          status     = pos_list_pkg::ST_DONE;
          do_ins     = cmd_valid;
          count_next = count + CNT_W'(1);
        end
      end
      pos_list_pkg::OP_DELETE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status = pos_list_pkg::ST_BAD_POS;
        end else begin
          status     = pos_list_pkg::ST_DONE;
          do_del     = cmd_valid;
          count_next = count - CNT_W'(1);
        end
      end
      pos_list_pkg::OP_EMPTY: begin
        status     = pos_list_pkg::ST_DONE;
        count_next = '0;
      end
      default: begin
        status = pos_list_pkg::ST_BAD_POS;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      stored_next[i] = stored[i];
      if (do_ins) begin
        if (CMP_W'(i) == pos_m1) begin
          stored_next[i] = cmd_q.value;
        end else if (i > 0 && CMP_W'(i) > pos_m1) begin
          stored_next[i] = stored[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i < CAP - 1 && CMP_W'(i) >= pos_m1) begin
          stored_next[i] = stored[(i < CAP - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      stored[i] <= stored_next[i];
    end
  end

  always_comb begin
    result_next.status        = status;
    result_next.removed_value = do_del ? stored[pos_idx] : '0;
    result_next.entry_count   = 8'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd_valid;
      if (cmd_valid) begin
        count <= count_next;
      end
    end
    if (cmd_valid) begin
      result <= result_next;
    end
  end

endmodule

>>> verif/tb.sv
// testbench for positional_list_insert_delete: random and directed list commands
// checked against an in-bench list tracker; depends on rtl/pos_list_pkg.sv and the rtl top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 200000;
  localparam int FULL_ATTEMPTS = 12;

  typedef enum {GROW, SHRINK} trend_t;

  class list_tracker;
    logic signed [31:0] entries [pos_list_pkg::CAPACITY];
    int count;
    int mismatches;
    pos_list_pkg::result_t expected_results [$];

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function void note_command(pos_list_pkg::cmd_t c);
      pos_list_pkg::result_t r;
      int p;
      r = '0;
      p = c.position;
      case (c.operation)
        pos_list_pkg::OP_INSERT: begin
          if (p < 1 || p > count + 1) begin
            r.status = pos_list_pkg::ST_BAD_POS;
          end else if (count >= pos_list_pkg::CAPACITY) begin
            r.status = pos_list_pkg::ST_FULL;
          end else begin
            for (int i = count; i >= p; i--) entries[i] = entries[i-1];
            entries[p-1] = c.value;
            count++;
            r.status = pos_list_pkg::ST_DONE;
          end
        end
        pos_list_pkg::OP_DELETE: begin
          if (p < 1 || p > count) begin
            r.status = pos_list_pkg::ST_BAD_POS;
          end else begin
            r.removed_value = entries[p-1];
            for (int i = p - 1; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
            r.status = pos_list_pkg::ST_DONE;
          end
        end
        pos_list_pkg::OP_EMPTY: begin
          count = 0;
          r.status = pos_list_pkg::ST_DONE;
        end
        default: begin
          r.status = pos_list_pkg::ST_BAD_POS;
        end
      endcase
      r.entry_count = 8'(count);
      expected_results.push_back(r);
    endfunction

    function void check_result(pos_list_pkg::result_t r);
      pos_list_pkg::result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d removed_value %0d entry_count %0d",
               r.status, r.removed_value, r.entry_count);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (r.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, r.status);
        mismatches++;
      end
      if (r.removed_value !== e.removed_value) begin
        $error("removed_value: expected %0d, actual %0d", e.removed_value, r.removed_value);
        mismatches++;
      end
      if (r.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, r.entry_count);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pos_list_pkg::cmd_t cmd = '0;
  logic done;
  pos_list_pkg::result_t result;
  int cycles = 0;
  list_tracker tracker;

  positional_list_insert_delete uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_command(cmd);
      if (done) tracker.check_result(result);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [31:0] val, input logic [7:0] pos);
    start <= 1'b1;
    cmd.operation <= op;
    cmd.value <= val;
    cmd.position <= pos;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and let every pending result come back
  task automatic await_idle();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_position(input int lim);
    if (lim < 1) return 8'd1;
    case ($urandom_range(3))
      0: return 8'd1;
      1: return 8'(lim);
      default: return 8'($urandom_range(lim, 1));
    endcase
  endfunction

  task automatic random_item(input trend_t trend);
    int roll;
    int n;
    logic grow_step;
    roll = $urandom_range(99);
    n = tracker.count;
    if (roll < 2) begin
      issue(2'($urandom_range(3)), pick_value(), 8'd0);
    end else if (roll < 6) begin
      issue(2'($urandom_range(1)), pick_value(), 8'($urandom_range(255)));
    end else if (roll < 8) begin
      issue(OP_UNKNOWN, pick_value(), 8'($urandom_range(255)));
    end else if (roll == 8 && trend == SHRINK) begin
      issue(pos_list_pkg::OP_EMPTY, pick_value(), 8'($urandom_range(255)));
    end else begin
      grow_step = (trend == GROW) ? (roll < 82) : (roll < 24);
      if (grow_step) issue(pos_list_pkg::OP_INSERT, pick_value(), pick_position(n + 1));
      else issue(pos_list_pkg::OP_DELETE, pick_value(), pick_position(n));
    end
  endtask

  initial begin
    trend_t trend;
    int burst;
    int full_hits;
    tracker = new();
    trend = GROW;
    burst = 0;
    full_hits = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: rejects on an empty list, ends and middle, empty
    issue(pos_list_pkg::OP_INSERT, 32'h1234_5678, 8'd0);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd1);
    issue(OP_UNKNOWN, 32'hffff_ffff, 8'd1);
    issue(pos_list_pkg::OP_INSERT, 32'h0, 8'd2);
    issue(pos_list_pkg::OP_INSERT, 32'h8000_0000, 8'd1);
    issue(pos_list_pkg::OP_INSERT, 32'h7fff_ffff, 8'd2);
    issue(pos_list_pkg::OP_INSERT, 32'hffff_ffff, 8'd1);
    issue(pos_list_pkg::OP_INSERT, 32'h0000_0000, 8'd2);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd5);
    issue(pos_list_pkg::OP_INSERT, 32'h5555_5555, 8'd6);
    issue(pos_list_pkg::OP_INSERT, 32'haaaa_aaaa, 8'd255);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd4);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd1);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd0);
    issue(pos_list_pkg::OP_EMPTY, 32'h0, 8'd0);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd1);
    issue(pos_list_pkg::OP_EMPTY, 32'hffff_ffff, 8'd255);
    issue(pos_list_pkg::OP_INSERT, 32'h5555_5555, 8'd1);
    issue(pos_list_pkg::OP_INSERT, 32'haaaa_aaaa, 8'd1);
    issue(pos_list_pkg::OP_DELETE, 32'h0, 8'd2);
    await_idle();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (tracker.count >= pos_list_pkg::CAPACITY) full_hits++;
      if (trend == GROW && full_hits >= FULL_ATTEMPTS) begin
        trend = SHRINK;
        full_hits = 0;
      end else if (trend == SHRINK && tracker.count == 0) begin
        trend = GROW;
      end
      if (k == RANDOM_ITEMS / 2) await_idle();
      if (burst == 0) begin
        hold_off($urandom_range(6, 1));
        burst = ($urandom_range(3) == 0) ? $urandom_range(150, 50) : $urandom_range(12, 1);
      end
      random_item(trend);
      burst--;
    end

    await_idle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
